@@ hdl/spra_pkg.sv @@
// shared types and constants for the scratchpad region allocator
// no dependencies; imported by scratchpad_region_allocator
package spra_pkg;

    // field widths of the stream words
    localparam int OPCODE_W   = 3;
    localparam int REQ_W      = 24;
    localparam int STATUS_W   = 3;
    localparam int OUT_PTR_W  = 19;
    localparam int EPOCH_W    = 32;
    localparam int COUNT_W    = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 160;

    // request size plus alignment slack, and the rounded size
    localparam int NPLUS_W    = 25;
    localparam int SIZE_W     = 25;
    localparam int RECIP_W    = NPLUS_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TEMP_ALLOC    = 3'd0,
        OP_PERSIST_ALLOC = 3'd1,
        OP_SUPER_ALLOC   = 3'd2,
        OP_RESET_TEMP    = 3'd3,
        OP_RESET_ALL     = 3'd4,
        OP_REGISTER      = 3'd5,
        OP_UNREGISTER    = 3'd6,
        OP_RELEASE       = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_LOCKED    = 3'd1,
        ST_NOSPACE   = 3'd2,
        ST_PERSIST   = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_OVERFLOW  = 3'd5
    } status_t;

endpackage

@@ hdl/scratchpad_region_allocator.sv @@
// scratchpad region allocator: temp / persistent / super-persistent regions
// depends on spra_pkg (opcodes, status codes, field widths)
//
// usage
//   s_axis: one request word per handshake; tuser carries the opcode,
//     tdata carries the request size and the arena lock flag
//   m_axis: exactly one result word per request, in request order; tuser
//     carries the status, tdata the grant offset and the state after the step
// pipeline and throughput
//   a request accepted on s_axis passes the input register, size rounding
//   over two multiply stages (reciprocal then alignment), then the pointer
//   update that loads the result register; one request per cycle sustained
//   while m_axis_tready is high; the pointer update is a single add and
//   compare per region, so back-to-back requests see each other's state
// reset
//   rst_n low clears the pipeline; temp region empty, persistent and super
//   regions empty (both at USABLE_BYTES), epochs and instance count zero
// stalls
//   when m_axis_tready is low the result word holds; bubbles in the pipe
//   still fill, and s_axis_tready drops only once every stage is occupied
module scratchpad_region_allocator
    import spra_pkg::*;
#(
    parameter int USABLE_BYTES = 262144,
    parameter int ALIGN_BYTES  = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [23:0] request_bytes, [24] arena_locked, [31:25] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] opcode
    input  logic [OPCODE_W-1:0]  s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [18:0] offset, [37:19] temp_top, [56:38] persist_bottom,
    // [75:57] floor_level, [107:76] temp_epoch, [139:108] persist_epoch,
    // [155:140] live_instances, [156] release_pending, [159:157] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [STATUS_W-1:0]  m_axis_tuser
);

    // pointer width follows the scratchpad size
    localparam int PTR_W   = $clog2(USABLE_BYTES + 1);
    localparam int CMP_W   = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 1;
    localparam int ALIGN_W = $clog2(ALIGN_BYTES + 1);
    localparam int SHIFT   = NPLUS_W + $clog2(ALIGN_BYTES);
    localparam int PROD_W  = NPLUS_W + RECIP_W;
    localparam int MUL2_W  = NPLUS_W + ALIGN_W;

    // ceil(2^SHIFT / ALIGN_BYTES): exact floor division for NPLUS_W-bit values
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_WIDE);
    localparam logic [PTR_W-1:0]   USABLE    = PTR_W'(USABLE_BYTES);
    localparam logic [NPLUS_W-1:0] ALIGN_M1  = NPLUS_W'(ALIGN_BYTES - 1);
    localparam logic [ALIGN_W-1:0] ALIGN_VAL = ALIGN_W'(ALIGN_BYTES);

    // ---------------------------------------------------------------
    // pipeline handshake: a stage takes a word when empty or draining
    // ---------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, m_valid_reg;
    logic out_take, c_take, b_take, a_take;

    assign out_take      = !m_valid_reg || m_axis_tready;
    assign c_take        = !c_valid_reg || out_take;
    assign b_take        = !b_valid_reg || c_take;
    assign a_take        = !a_valid_reg || b_take;
    assign s_axis_tready = a_take;
    assign m_axis_tvalid = m_valid_reg;

    // stage a: captured request with alignment slack added
    op_t                a_op_reg;
    logic               a_locked_reg;
    logic [NPLUS_W-1:0] a_plus_reg;
    // stage b: quotient by the alignment
    op_t                b_op_reg;
    logic               b_locked_reg;
    logic [NPLUS_W-1:0] b_quot_reg;
    // stage c: rounded size
    op_t                c_op_reg;
    logic               c_locked_reg;
    logic [SIZE_W-1:0]  c_size_reg;

    logic [PROD_W-1:0]  recip_prod;
    logic [MUL2_W-1:0]  align_prod;

    assign recip_prod = PROD_W'(a_plus_reg) * PROD_W'(RECIP);
    assign align_prod = MUL2_W'(b_quot_reg) * MUL2_W'(ALIGN_VAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_take)
            begin
                a_valid_reg <= s_axis_tvalid;
            end
            if (b_take)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_take)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take && s_axis_tvalid)
        begin
            a_op_reg     <= op_t'(s_axis_tuser);
            a_locked_reg <= s_axis_tdata[REQ_W];
            a_plus_reg   <= NPLUS_W'(s_axis_tdata[REQ_W-1:0]) + ALIGN_M1;
        end
        if (b_take && a_valid_reg)
        begin
            b_op_reg     <= a_op_reg;
            b_locked_reg <= a_locked_reg;
            b_quot_reg   <= NPLUS_W'(recip_prod >> SHIFT);
        end
        if (c_take && b_valid_reg)
        begin
            c_op_reg     <= b_op_reg;
            c_locked_reg <= b_locked_reg;
            c_size_reg   <= SIZE_W'(align_prod);
        end
    end

    // ---------------------------------------------------------------
    // allocator state and the next-state update
    // ---------------------------------------------------------------
    logic [PTR_W-1:0]   temp_end_reg, temp_end_next;
    logic [PTR_W-1:0]   persist_start_reg, persist_start_next;
    logic [PTR_W-1:0]   floor_reg, floor_next;
    logic [EPOCH_W-1:0] gen_count_reg, gen_count_next;
    logic [EPOCH_W-1:0] persist_gen_reg, persist_gen_next;
    logic [COUNT_W-1:0] instance_count_reg, instance_count_next;
    logic               deferred_reg, deferred_next;
    status_t            status_next;
    logic [CMP_W-1:0]   grant_next;

    logic [CMP_W-1:0]   temp_w, persist_w, floor_w, size_w;
    logic [CMP_W-1:0]   temp_plus, persist_minus, floor_minus;
    logic               commit;

    assign temp_w        = CMP_W'(temp_end_reg);
    assign persist_w     = CMP_W'(persist_start_reg);
    assign floor_w       = CMP_W'(floor_reg);
    assign size_w        = CMP_W'(c_size_reg);
    assign temp_plus     = temp_w + size_w;
    assign persist_minus = persist_w - size_w;
    assign floor_minus   = floor_w - size_w;
    assign commit        = c_valid_reg && out_take;

    always_comb
    begin
        temp_end_next       = temp_end_reg;
        persist_start_next  = persist_start_reg;
        floor_next          = floor_reg;
        gen_count_next      = gen_count_reg;
        persist_gen_next    = persist_gen_reg;
        instance_count_next = instance_count_reg;
        deferred_next       = deferred_reg;
        status_next         = ST_OK;
        grant_next          = '0;

        // the arena lock blocks every allocation and reset
        if (c_locked_reg && (c_op_reg == OP_TEMP_ALLOC || c_op_reg == OP_PERSIST_ALLOC ||
                             c_op_reg == OP_SUPER_ALLOC || c_op_reg == OP_RESET_TEMP ||
                             c_op_reg == OP_RESET_ALL))
        begin
            status_next = ST_LOCKED;
        end
        else
        begin
            case (c_op_reg)
                OP_TEMP_ALLOC:
                begin
                    if (temp_plus > persist_w)
                    begin
                        status_next = ST_NOSPACE;
                    end
                    else
                    begin
                        grant_next    = temp_w;
                        temp_end_next = PTR_W'(temp_plus);
                    end
                end
                OP_PERSIST_ALLOC:
                begin
                    if (persist_w < size_w || persist_minus < temp_w)
                    begin
                        status_next = ST_NOSPACE;
                    end
                    else
                    begin
                        persist_start_next = PTR_W'(persist_minus);
                        grant_next         = persist_minus;
                    end
                end
                OP_SUPER_ALLOC:
                begin
                    // floor moves only with no persistent space held
                    if (persist_start_reg != floor_reg)
                    begin
                        status_next = ST_PERSIST;
                    end
                    else if (floor_w < size_w || floor_minus < temp_w)
                    begin
                        status_next = ST_NOSPACE;
                    end
                    else
                    begin
                        floor_next         = PTR_W'(floor_minus);
                        persist_start_next = PTR_W'(floor_minus);
                        grant_next         = floor_minus;
                    end
                end
                OP_RESET_TEMP:
                begin
                    temp_end_next  = '0;
                    gen_count_next = gen_count_reg + 1'b1;
                end
                OP_RESET_ALL:
                begin
                    temp_end_next      = '0;
                    persist_start_next = floor_reg;
                    gen_count_next     = gen_count_reg + 1'b1;
                    persist_gen_next   = persist_gen_reg + 1'b1;
                end
                OP_REGISTER:
                begin
                    if (instance_count_reg == COUNT_MAX)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        instance_count_next = instance_count_reg + 1'b1;
                    end
                end
                OP_UNREGISTER:
                begin
                    if (instance_count_reg == '0)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        instance_count_next = instance_count_reg - 1'b1;
                        // last instance gone: give back the floor, or defer it
                        if (instance_count_reg == COUNT_W'(1) && floor_reg < USABLE)
                        begin
                            if (c_locked_reg)
                            begin
                                deferred_next = 1'b1;
                            end
                            else
                            begin
                                temp_end_next      = '0;
                                floor_next         = USABLE;
                                persist_start_next = USABLE;
                                gen_count_next     = gen_count_reg + 1'b1;
                                persist_gen_next   = persist_gen_reg + 1'b1;
                                deferred_next      = 1'b0;
                            end
                        end
                    end
                end
                OP_RELEASE:
                begin
                    if (deferred_reg && !c_locked_reg && instance_count_reg == '0)
                    begin
                        temp_end_next      = '0;
                        floor_next         = USABLE;
                        persist_start_next = USABLE;
                        gen_count_next     = gen_count_reg + 1'b1;
                        persist_gen_next   = persist_gen_reg + 1'b1;
                        deferred_next      = 1'b0;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_end_reg       <= '0;
            persist_start_reg  <= USABLE;
            floor_reg          <= USABLE;
            gen_count_reg      <= '0;
            persist_gen_reg    <= '0;
            instance_count_reg <= '0;
            deferred_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                temp_end_reg       <= temp_end_next;
                persist_start_reg  <= persist_start_next;
                floor_reg          <= floor_next;
                gen_count_reg      <= gen_count_next;
                persist_gen_reg    <= persist_gen_next;
                instance_count_reg <= instance_count_next;
                deferred_reg       <= deferred_next;
            end
            if (out_take)
            begin
                m_valid_reg <= c_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    status_t            r_status_reg;
    logic [OUT_PTR_W-1:0] r_offset_reg, r_temp_reg, r_persist_reg, r_floor_reg;
    logic [EPOCH_W-1:0] r_gen_reg, r_pgen_reg;
    logic [COUNT_W-1:0] r_count_reg;
    logic               r_pending_reg;

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            r_status_reg  <= status_next;
            r_offset_reg  <= grant_next[OUT_PTR_W-1:0];
            r_temp_reg    <= OUT_PTR_W'(CMP_W'(temp_end_next));
            r_persist_reg <= OUT_PTR_W'(CMP_W'(persist_start_next));
            r_floor_reg   <= OUT_PTR_W'(CMP_W'(floor_next));
            r_gen_reg     <= gen_count_next;
            r_pgen_reg    <= persist_gen_next;
            r_count_reg   <= instance_count_next;
            r_pending_reg <= deferred_next;
        end
    end

    assign m_axis_tuser = r_status_reg;
    assign m_axis_tdata = {3'b000, r_pending_reg, r_count_reg, r_pgen_reg, r_gen_reg,
                           r_floor_reg, r_persist_reg, r_temp_reg, r_offset_reg};

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // the three regions never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        temp_end_reg <= persist_start_reg)
        else $error("temp region runs into persistent region");

    assert property (@(posedge clk) disable iff (!rst_n)
        persist_start_reg <= floor_reg)
        else $error("persistent region runs past the floor");

    assert property (@(posedge clk) disable iff (!rst_n)
        floor_reg <= USABLE)
        else $error("floor above the scratchpad end");

    // a pending release always has a lowered floor to give back
    assert property (@(posedge clk) disable iff (!rst_n)
        deferred_reg |-> floor_reg != USABLE)
        else $error("release pending with nothing to release");

endmodule
